[rtl/dcdp_pkg.sv]
// ----------------------------------------------------------------------------
// dcdp_pkg: shared definitions for the dual channel drive PID unit
// Widths, limits, register codes and the structs passed between modules.
// ----------------------------------------------------------------------------
package dcdp_pkg;

  localparam int POS_W     = 24;  // encoder position
  localparam int TGT_W     = 10;  // target in inches
  localparam int TCNT_W    = 16;  // target scaled to counts
  localparam int GAIN_W    = 20;  // unsigned Q4.16 gain
  localparam int ERR_W     = 26;  // error and derivative
  localparam int SUM_W     = 10;  // bounded integral
  localparam int PROD_W    = ERR_W + GAIN_W + 1;
  localparam int IPROD_W   = SUM_W + GAIN_W + 1;
  localparam int ACC_W     = PROD_W + 1;
  localparam int FRAC_W    = 16;
  localparam int PWR_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;

  localparam logic signed [TCNT_W-1:0] CNT_PER_INCH = 16'sd59;
  localparam int DONE_LIMIT = 5;
  localparam int SUM_LIMIT  = 300;

  localparam logic [GAIN_W-1:0] LEFT_KP_RST  = 20'd38339;
  localparam logic [GAIN_W-1:0] LEFT_KI_RST  = 20'd33;
  localparam logic [GAIN_W-1:0] LEFT_KD_RST  = 20'd328;
  localparam logic [GAIN_W-1:0] RIGHT_KP_RST = 20'd39322;
  localparam logic [GAIN_W-1:0] RIGHT_KI_RST = 20'd33;
  localparam logic [GAIN_W-1:0] RIGHT_KD_RST = 20'd328;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_TARGET  = 3'd0,
    REG_RIGHT_TARGET = 3'd1,
    REG_LEFT_KP      = 3'd2,
    REG_LEFT_KI      = 3'd3,
    REG_LEFT_KD      = 3'd4,
    REG_RIGHT_KP     = 3'd5,
    REG_RIGHT_KI     = 3'd6,
    REG_RIGHT_KD     = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]  left_target;
    logic [TGT_W-1:0]  right_target;
    logic [GAIN_W-1:0] left_kp;
    logic [GAIN_W-1:0] left_ki;
    logic [GAIN_W-1:0] left_kd;
    logic [GAIN_W-1:0] right_kp;
    logic [GAIN_W-1:0] right_ki;
    logic [GAIN_W-1:0] right_kd;
  } cfg_t;

  // Load strobes for the three pipeline stages behind the input register.
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } pipe_ctrl_t;

endpackage

[rtl/dcdp_cfg.sv]
// ----------------------------------------------------------------------------
// dcdp_cfg: configuration register file
// Holds the two targets and six gains; a write is always accepted and registered.
// ----------------------------------------------------------------------------
module dcdp_cfg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dcdp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dcdp_pkg::CFG_DAT_W-1:0]       cfg_data,
  output dcdp_pkg::cfg_t                       cfg
);
  import dcdp_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_LEFT_TARGET:  cfg_nxt.left_target  = cfg_data[TGT_W-1:0];
        REG_RIGHT_TARGET: cfg_nxt.right_target = cfg_data[TGT_W-1:0];
        REG_LEFT_KP:      cfg_nxt.left_kp      = cfg_data[GAIN_W-1:0];
        REG_LEFT_KI:      cfg_nxt.left_ki      = cfg_data[GAIN_W-1:0];
        REG_LEFT_KD:      cfg_nxt.left_kd      = cfg_data[GAIN_W-1:0];
        REG_RIGHT_KP:     cfg_nxt.right_kp     = cfg_data[GAIN_W-1:0];
        REG_RIGHT_KI:     cfg_nxt.right_ki     = cfg_data[GAIN_W-1:0];
        REG_RIGHT_KD:     cfg_nxt.right_kd     = cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_target  <= '0;
      cfg_r.right_target <= '0;
      cfg_r.left_kp      <= LEFT_KP_RST;
      cfg_r.left_ki      <= LEFT_KI_RST;
      cfg_r.left_kd      <= LEFT_KD_RST;
      cfg_r.right_kp     <= RIGHT_KP_RST;
      cfg_r.right_ki     <= RIGHT_KI_RST;
      cfg_r.right_kd     <= RIGHT_KD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/dcdp_side.sv]
// ----------------------------------------------------------------------------
// dcdp_side: datapath of one PID channel
// Error, derivative and integral (zeroed past its limit), then the three gain products,
// then the sum, truncation toward zero and 16-bit saturation.
// ----------------------------------------------------------------------------
module dcdp_side (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  dcdp_pkg::pipe_ctrl_t                     ctrl,
  input  logic signed [dcdp_pkg::POS_W-1:0]        pos_a,
  input  logic signed [dcdp_pkg::POS_W-1:0]        pos_b,
  input  logic signed [dcdp_pkg::TGT_W-1:0]        target,
  input  logic        [dcdp_pkg::GAIN_W-1:0]       kp,
  input  logic        [dcdp_pkg::GAIN_W-1:0]       ki,
  input  logic        [dcdp_pkg::GAIN_W-1:0]       kd,
  output logic signed [dcdp_pkg::PWR_W-1:0]        power,
  output logic                                     err_small
);
  import dcdp_pkg::*;

  localparam logic signed [ERR_W-1:0] SUM_HI  = ERR_W'(SUM_LIMIT);
  localparam logic signed [ERR_W-1:0] SUM_LO  = -SUM_HI;
  localparam logic signed [ERR_W-1:0] DONE_HI = ERR_W'(DONE_LIMIT);
  localparam logic signed [ERR_W-1:0] DONE_LO = -DONE_HI;

  // Stage 1: error terms. err_r and sum_r are also the controller state.
  logic signed [POS_W:0]    pair_sum;
  logic signed [POS_W:0]    pair_adj;
  logic signed [POS_W-1:0]  avg;
  logic signed [TCNT_W-1:0] tgt_ext;
  logic signed [TCNT_W-1:0] tgt_cnt;
  logic signed [ERR_W-1:0]  err_nxt;
  logic signed [ERR_W-1:0]  der_nxt;
  logic signed [ERR_W-1:0]  isum_full;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     small_nxt;
  logic signed [ERR_W-1:0]  err_r;
  logic signed [ERR_W-1:0]  der_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     small1_r;

  // Stage 2: products.
  logic signed [PROD_W-1:0]  prod_p_nxt;
  logic signed [IPROD_W-1:0] prod_i_nxt;
  logic signed [PROD_W-1:0]  prod_d_nxt;
  logic signed [PROD_W-1:0]  prod_p_r;
  logic signed [IPROD_W-1:0] prod_i_r;
  logic signed [PROD_W-1:0]  prod_d_r;
  logic                      small2_r;

  // Stage 3: sum and output.
  logic signed [ACC_W-1:0]         acc;
  logic signed [ACC_W-1:0]         acc_adj;
  logic signed [ACC_W-FRAC_W-1:0]  quot;
  logic [ACC_W-FRAC_W-PWR_W:0]     quot_top;
  logic signed [PWR_W-1:0]         power_nxt;
  logic signed [PWR_W-1:0]         power_r;
  logic                            small3_r;

  // Average of the two encoders, rounded toward zero.
  assign pair_sum = {pos_a[POS_W-1], pos_a} + {pos_b[POS_W-1], pos_b};
  assign pair_adj = pair_sum + {{POS_W{1'b0}}, pair_sum[POS_W]};
  assign avg      = pair_adj[POS_W:1];

  assign tgt_ext = {{(TCNT_W-TGT_W){target[TGT_W-1]}}, target};
  assign tgt_cnt = tgt_ext * CNT_PER_INCH;

  assign err_nxt = {{(ERR_W-TCNT_W){tgt_cnt[TCNT_W-1]}}, tgt_cnt}
                 - {{(ERR_W-POS_W){avg[POS_W-1]}}, avg};
  assign der_nxt = err_nxt - err_r;

  // The integral is dropped to zero once its magnitude runs past the limit.
  assign isum_full = {{(ERR_W-SUM_W){sum_r[SUM_W-1]}}, sum_r} + err_nxt;
  assign sum_nxt   = (isum_full > SUM_HI || isum_full < SUM_LO) ? '0
                                                                 : isum_full[SUM_W-1:0];
  assign small_nxt = (err_nxt < DONE_HI) && (err_nxt > DONE_LO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_r <= '0;
      sum_r <= '0;
    end else if (ctrl.ld1) begin
      err_r <= err_nxt;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      der_r    <= der_nxt;
      small1_r <= small_nxt;
    end
  end

  assign prod_p_nxt = err_r * $signed({1'b0, kp});
  assign prod_i_nxt = sum_r * $signed({1'b0, ki});
  assign prod_d_nxt = der_r * $signed({1'b0, kd});

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
      small2_r <= small1_r;
    end
  end

  assign acc = {prod_p_r[PROD_W-1], prod_p_r}
             + {{(ACC_W-IPROD_W){prod_i_r[IPROD_W-1]}}, prod_i_r}
             + {prod_d_r[PROD_W-1], prod_d_r};

  // Bias negative values so the arithmetic shift truncates toward zero.
  assign acc_adj  = acc + {{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{acc[ACC_W-1]}}};
  assign quot     = acc_adj[ACC_W-1:FRAC_W];
  assign quot_top = quot[ACC_W-FRAC_W-1:PWR_W-1];

  always_comb begin
    if ((&quot_top) || !(|quot_top)) begin
      power_nxt = quot[PWR_W-1:0];
    end else if (quot[ACC_W-FRAC_W-1]) begin
      power_nxt = {1'b1, {(PWR_W-1){1'b0}}};
    end else begin
      power_nxt = {1'b0, {(PWR_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld3) begin
      power_r  <= power_nxt;
      small3_r <= small2_r;
    end
  end

  assign power     = power_r;
  assign err_small = small3_r;

endmodule

[rtl/dual_channel_drive_pid_unit.sv]
// ----------------------------------------------------------------------------
// dual_channel_drive_pid_unit: two-sided drive distance PID controller
// Top level: input register, pipeline flow control, config and two channels.
// ----------------------------------------------------------------------------
// Each accepted input beat carries four encoder positions and produces exactly
// one output beat with the left and right motor power and a done flag. The
// unit takes one beat per clock cycle for as long as the output side keeps
// up; the result passes, in order, through the input register, the error
// stage, the multiplier stage and the output register. Stalls propagate back
// only through full stages, so a result waiting on out_stall does not block
// new input while an empty stage remains. The error history and integral of
// each side advance once per beat, in order. The user must write targets and
// gains through the cfg_ port only while no beat is in flight; the block does
// not enforce this. Writes always complete in the cycle they are offered.
// ----------------------------------------------------------------------------
module dual_channel_drive_pid_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dcdp_pkg::POS_W-1:0]      in_back_left_pos,
  input  logic signed [dcdp_pkg::POS_W-1:0]      in_front_left_pos,
  input  logic signed [dcdp_pkg::POS_W-1:0]      in_back_right_pos,
  input  logic signed [dcdp_pkg::POS_W-1:0]      in_front_right_pos,

  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dcdp_pkg::PWR_W-1:0]      out_left_power,
  output logic signed [dcdp_pkg::PWR_W-1:0]      out_right_power,
  output logic                                   out_move_done,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dcdp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dcdp_pkg::CFG_DAT_W-1:0]         cfg_data
);
  import dcdp_pkg::*;

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  // Valid bits for the input register, the two middle stages and the output.
  logic v0_r, v1_r, v2_r, v3_r;
  logic adv0, adv1, adv2, adv3;
  logic ld0;

  logic signed [POS_W-1:0] bl_r, fl_r, br_r, fr_r;

  logic left_small, right_small;

  // A stage can take a new beat when it is empty or its content moves on.
  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign adv0 = !v0_r || adv1;

  assign in_stall = !adv0;
  assign ld0      = in_valid && adv0;

  assign ctrl.ld1 = v0_r && adv1;
  assign ctrl.ld2 = v1_r && adv2;
  assign ctrl.ld3 = v2_r && adv3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv0) begin
        v0_r <= in_valid;
      end
      if (adv1) begin
        v1_r <= v0_r;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld0) begin
      bl_r <= in_back_left_pos;
      fl_r <= in_front_left_pos;
      br_r <= in_back_right_pos;
      fr_r <= in_front_right_pos;
    end
  end

  dcdp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dcdp_side u_left (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .pos_a     (bl_r),
    .pos_b     (fl_r),
    .target    ($signed(cfg.left_target)),
    .kp        (cfg.left_kp),
    .ki        (cfg.left_ki),
    .kd        (cfg.left_kd),
    .power     (out_left_power),
    .err_small (left_small)
  );

  dcdp_side u_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .pos_a     (br_r),
    .pos_b     (fr_r),
    .target    ($signed(cfg.right_target)),
    .kp        (cfg.right_kp),
    .ki        (cfg.right_ki),
    .kd        (cfg.right_kd),
    .power     (out_right_power),
    .err_small (right_small)
  );

  // Done is judged afresh on every beat and does not latch.
  assign out_move_done = left_small && right_small;
  assign out_valid     = v3_r;

endmodule
